/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: circular deque shared definitions
// Command and status codes, request/response payloads and cell controls.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned WORD_W       = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // per-cycle action broadcast to every cell of a chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_REM  = 2'd2,
    CELL_PUT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic [7:0]               entry_count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic                     is_empty;
  } rsp_t;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

/* rtl/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of a deque chain
// Holds one word; shifts in from either neighbor or loads the broadcast word.
// ----------------------------------------------------------------------------
module cdq_cell #(
  parameter int unsigned CNT_W = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic                             clk_i,
  input  cdq_pkg::cell_ctl_t               ctl_i,
  input  logic [CNT_W-1:0]                 count_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] prev_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] next_i,
  output logic signed [cdq_pkg::WORD_W-1:0] data_o
);

  logic signed [cdq_pkg::WORD_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      cdq_pkg::CELL_INS: data_d = prev_i;
      cdq_pkg::CELL_REM: data_d = next_i;
      cdq_pkg::CELL_PUT: begin
        // append lands in the first free cell
        if (count_i == CNT_W'(IDX)) data_d = ctl_i.word;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/cdq_chain.sv */
// ----------------------------------------------------------------------------
// cdq_chain: row of deque cells with the head at cell 0
// Insert shifts toward the tail, remove shifts toward the head.
// ----------------------------------------------------------------------------
module cdq_chain #(
  parameter int unsigned CAPACITY = cdq_pkg::CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  cdq_pkg::cell_ctl_t                ctl_i,
  input  logic [CNT_W-1:0]                  count_i,
  output logic signed [cdq_pkg::WORD_W-1:0] head_o
);

  logic signed [cdq_pkg::WORD_W-1:0] data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [cdq_pkg::WORD_W-1:0] prev, next;

    if (i == 0) begin : g_first
      assign prev = ctl_i.word;
    end else begin : g_mid
      assign prev = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = data[i+1];
    end

    cdq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .count_i (count_i),
      .prev_i  (prev),
      .next_i  (next),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule

/* rtl/circular_deque_top.sv */
// ----------------------------------------------------------------------------
// circular_deque_top: double-ended queue of signed words
// A request's result is registered and strobed in the cycle after it is taken.
// Throughput: one request per cycle while busy is low; at most one chain shifts.
// busy is high for the first cycle after reset, low afterwards.
// Reset clears the entry count; cell contents are not reset and are unread
// until written.
// ----------------------------------------------------------------------------
module circular_deque_top #(
  parameter int unsigned CAPACITY = cdq_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cdq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output cdq_pkg::rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Two copies of the contents: chain A has the front word at its head,
  // chain B holds the same words reversed with the back word at its head.
  cdq_pkg::cell_ctl_t                ctl_a, ctl_b;
  logic signed [cdq_pkg::WORD_W-1:0] head_a, head_b;

  logic [CNT_W-1:0]                  count_q, count_d;
  logic                              valid_q, busy_q;
  cdq_pkg::status_e                  status_q, status_d;
  logic signed [cdq_pkg::WORD_W-1:0] popped_q, popped_d;
  logic                              accept, full, empty;
  logic [CNT_W+7:0]                  count_ext;

  assign accept = start & ~busy_q;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);

  always_comb begin
    ctl_a.op   = cdq_pkg::CELL_HOLD;
    ctl_b.op   = cdq_pkg::CELL_HOLD;
    ctl_a.word = req_i.push_value;
    ctl_b.word = req_i.push_value;
    count_d    = count_q;
    status_d   = cdq_pkg::STS_DONE;
    popped_d   = '0;
    if (accept) begin
      case (cdq_pkg::cmd_e'(req_i.command))
        cdq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = cdq_pkg::STS_FULL;
          end else begin
            ctl_a.op = cdq_pkg::CELL_INS;
            ctl_b.op = cdq_pkg::CELL_PUT;
            count_d  = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_d = cdq_pkg::STS_FULL;
          end else begin
            ctl_a.op = cdq_pkg::CELL_PUT;
            ctl_b.op = cdq_pkg::CELL_INS;
            count_d  = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_d = cdq_pkg::STS_EMPTY;
          end else begin
            popped_d = head_a;
            ctl_a.op = cdq_pkg::CELL_REM;
            count_d  = count_q - CNT_W'(1);
          end
        end
        cdq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_d = cdq_pkg::STS_EMPTY;
          end else begin
            popped_d = head_b;
            ctl_b.op = cdq_pkg::CELL_REM;
            count_d  = count_q - CNT_W'(1);
          end
        end
        default: ;  // peek and unused codes change nothing
      endcase
    end
  end

  cdq_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain_a (
    .clk_i   (clk_i),
    .ctl_i   (ctl_a),
    .count_i (count_q),
    .head_o  (head_a)
  );

  cdq_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain_b (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b),
    .count_i (count_q),
    .head_o  (head_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
      busy_q  <= 1'b1;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
      busy_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    popped_q <= popped_d;
  end

  // state only moves on the next request, so ends are read straight from the chains
  assign count_ext = {8'b0, count_q};

  assign busy                = busy_q;
  assign rsp_valid_o         = valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.popped_value  = popped_q;
  assign rsp_o.entry_count   = count_ext[7:0];
  assign rsp_o.front_value   = empty ? '0 : head_a;
  assign rsp_o.back_value    = empty ? '0 : head_b;
  assign rsp_o.is_empty      = empty;

endmodule
